// ----- hdl/can_rx_frame_queue_assert.svh -----
// Assertion shorthands for the receive queue checker.
// Each expects signals named clock and reset in the module that uses it.
`ifndef CAN_RX_FRAME_QUEUE_ASSERT_SVH
`define CAN_RX_FRAME_QUEUE_ASSERT_SVH

// Same-cycle implication.
`define CRQ_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("receive queue check failed");

// Next-cycle implication.
`define CRQ_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("receive queue check failed");

`endif

// ----- hdl/crq_pkg.sv -----
package crq_pkg;

   localparam int QUEUE_FRAMES = 8;
   localparam int MAX_BEATS    = 8;

   localparam int SLOT_W  = $clog2(QUEUE_FRAMES);
   localparam int FILL_W  = $clog2(QUEUE_FRAMES + 1);
   localparam int BEAT_W  = (MAX_BEATS > 1) ? $clog2(MAX_BEATS) : 1;
   localparam int PBEAT_W = $clog2(MAX_BEATS + 1);
   localparam int WORDS   = QUEUE_FRAMES * MAX_BEATS;
   localparam int ADDR_W  = $clog2(WORDS);
   localparam int LEN_MAX = MAX_BEATS * 8;

   // command queue between front and back
   localparam int CMDQ_DEPTH = 2;
   localparam int CMDQ_PTR_W = $clog2(CMDQ_DEPTH);
   localparam int CMDQ_CNT_W = $clog2(CMDQ_DEPTH + 1);

   localparam logic [1:0] CMD_PUSH    = 2'd0;
   localparam logic [1:0] CMD_POP     = 2'd1;
   localparam logic [1:0] CMD_BUS_OFF = 2'd2;

   localparam logic [2:0] KIND_BEAT    = 3'd0;
   localparam logic [2:0] KIND_EMPTY   = 3'd1;
   localparam logic [2:0] KIND_STORED  = 3'd2;
   localparam logic [2:0] KIND_DROPPED = 3'd3;
   localparam logic [2:0] KIND_STATUS  = 3'd4;

   localparam logic [1:0] OP_PUSH   = 2'd0;
   localparam logic [1:0] OP_POP    = 2'd1;
   localparam logic [1:0] OP_STATUS = 2'd2;

   typedef struct packed {
      logic [1:0]  cmd;
      logic [10:0] frame_id;
      logic [3:0]  dlc_code;
      logic [63:0] data_word;
      logic        first_beat;
      logic        last_beat;
   } in_item_type;

   typedef struct packed {
      logic [2:0]  kind;
      logic [10:0] out_id;
      logic [6:0]  out_length;
      logic [63:0] out_word;
      logic [2:0]  beat_number;
      logic        is_last;
      logic [31:0] dropped_total;
      logic        bus_off_flag;
      logic [3:0]  frames_waiting;
   } out_item_type;

   typedef struct packed {
      logic [1:0]  op;
      logic        set_bus_off;
      logic [10:0] frame_id;
      logic [6:0]  length;
      logic [63:0] data_word;
      logic        first_beat;
      logic        last_beat;
   } cmd_type;

   // CAN FD data length code to payload bytes
   function automatic logic [6:0] dlc_to_bytes(input logic [3:0] dlc);
      logic [6:0] bytes;
      case (dlc)
         4'd0:    bytes = 7'd0;
         4'd1:    bytes = 7'd1;
         4'd2:    bytes = 7'd2;
         4'd3:    bytes = 7'd3;
         4'd4:    bytes = 7'd4;
         4'd5:    bytes = 7'd5;
         4'd6:    bytes = 7'd6;
         4'd7:    bytes = 7'd7;
         4'd8:    bytes = 7'd8;
         4'd9:    bytes = 7'd12;
         4'd10:   bytes = 7'd16;
         4'd11:   bytes = 7'd20;
         4'd12:   bytes = 7'd24;
         4'd13:   bytes = 7'd32;
         4'd14:   bytes = 7'd48;
         default: bytes = 7'd64;
      endcase
      return bytes;
   endfunction

endpackage

// ----- hdl/can_rx_frame_queue.sv -----
// CAN FD receive queue with a saturating drop counter. A transaction is taken
// on a clock edge with start high and busy low; every transaction yields one or
// more results, each shown on rsp_item for exactly one cycle with rsp_strobe
// high. The receiver cannot stall, so it must take every strobed result. A push
// beat, a bus-off event or any other status command is executed when it reaches
// the head of the command queue, and its registered result is shown in the next
// cycle. A pop of a frame first reads the frame header and first word from the
// registered frame memory, then streams one beat per cycle, back to back, with
// the last marked. A pop on an empty queue answers with an empty report. A
// two-entry command queue sits in front of the execution stage, so up to two
// transactions are taken while a long pop is still streaming; busy rises only
// while that queue is full. The bus-off flag is sticky until reset.
module can_rx_frame_queue
   import crq_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   output logic         busy,
   input  in_item_type  req_item,
   output logic         rsp_strobe,
   output out_item_type rsp_item
);

   logic    head_valid;
   logic    head_take;
   cmd_type head;

   // Front: accept and classify transactions, buffer them in order.
   crq_front u_front (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_item   (req_item),
      .head_valid (head_valid),
      .head       (head),
      .head_take  (head_take)
   );

   // Back: hold frame storage, execute one command at a time, drive results.
   crq_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head       (head),
      .head_take  (head_take),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item)
   );

endmodule

// ----- hdl/crq_front.sv -----
module crq_front
   import crq_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  in_item_type req_item,
   output logic        head_valid,
   output cmd_type     head,
   input  logic        head_take
);

   cmd_type                 q_ff [CMDQ_DEPTH];
   logic [CMDQ_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [CMDQ_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CMDQ_CNT_W-1:0]   count_ff, count_in;
   logic                    accept;
   cmd_type                 entry;
   logic [6:0]              bytes;

   assign busy       = (count_ff == CMDQ_CNT_W'(CMDQ_DEPTH));
   assign accept     = start & ~busy;
   assign head_valid = (count_ff != '0);
   assign head       = q_ff[rd_ptr_ff];

   // classify the transaction and resolve the DLC
   always_comb begin
      bytes = dlc_to_bytes(req_item.dlc_code);
      entry.op          = OP_STATUS;
      entry.set_bus_off = 1'b0;
      entry.frame_id    = req_item.frame_id;
      entry.length      = (bytes > 7'(LEN_MAX)) ? 7'(LEN_MAX) : bytes;
      entry.data_word   = req_item.data_word;
      entry.first_beat  = req_item.first_beat;
      entry.last_beat   = req_item.last_beat;
      case (req_item.cmd)
         CMD_PUSH:    entry.op = OP_PUSH;
         CMD_POP:     entry.op = OP_POP;
         CMD_BUS_OFF: entry.set_bus_off = 1'b1;
         default:     entry.op = OP_STATUS;
      endcase
   end

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (accept) begin
         wr_ptr_in = (wr_ptr_ff == CMDQ_PTR_W'(CMDQ_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (head_take) begin
         rd_ptr_in = (rd_ptr_ff == CMDQ_PTR_W'(CMDQ_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({accept, head_take})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         q_ff[wr_ptr_ff] <= entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ----- hdl/crq_back.sv -----
module crq_back
   import crq_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         head_valid,
   input  cmd_type      head,
   output logic         head_take,
   output logic         rsp_strobe,
   output out_item_type rsp_item
);

   localparam logic S_IDLE = 1'b0;
   localparam logic S_POP  = 1'b1;

   logic                state_ff, state_in;
   logic [SLOT_W-1:0]   write_slot_ff, write_slot_in;
   logic [SLOT_W-1:0]   read_slot_ff, read_slot_in;
   logic [SLOT_W-1:0]   pop_slot_ff, pop_slot_in;
   logic [FILL_W-1:0]   fill_ff, fill_in;
   logic [PBEAT_W-1:0]  push_beat_ff, push_beat_in;
   logic [BEAT_W-1:0]   beat_ff, beat_in;
   logic                open_ff, open_in;
   logic                discarding_ff, discarding_in;
   logic [31:0]         drop_ff, drop_in;
   logic                bus_off_ff, bus_off_in;
   logic                rsp_strobe_ff, rsp_strobe_in;
   out_item_type        rsp_item_ff, rsp_item_in;

   logic [10:0]         id_mem_ff   [QUEUE_FRAMES];
   logic [6:0]          len_mem_ff  [QUEUE_FRAMES];
   logic [63:0]         word_mem_ff [WORDS];
   logic [10:0]         id_rd_ff;
   logic [6:0]          len_rd_ff;
   logic [63:0]         word_rd_ff;

   logic                meta_we, meta_re;
   logic                word_we, word_re;
   logic [ADDR_W-1:0]   word_waddr, word_raddr;

   function automatic logic [ADDR_W-1:0] word_addr(input logic [SLOT_W-1:0] slot,
                                                   input logic [BEAT_W-1:0] beat);
      return ADDR_W'(ADDR_W'(slot) * ADDR_W'(MAX_BEATS)) + ADDR_W'(beat);
   endfunction

   function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] slot);
      return (slot == SLOT_W'(QUEUE_FRAMES - 1)) ? '0 : slot + 1'b1;
   endfunction

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_item   = rsp_item_ff;

   always_comb begin
      logic               open_v, disc_v;
      logic [PBEAT_W-1:0] pb_v;
      logic [31:0]        drop_v;
      logic [2:0]         kind_v;
      logic [7:0]         sum_v;
      logic [3:0]         beats_v;
      logic               last_v;

      state_in      = state_ff;
      write_slot_in = write_slot_ff;
      read_slot_in  = read_slot_ff;
      pop_slot_in   = pop_slot_ff;
      fill_in       = fill_ff;
      push_beat_in  = push_beat_ff;
      beat_in       = beat_ff;
      open_in       = open_ff;
      discarding_in = discarding_ff;
      drop_in       = drop_ff;
      bus_off_in    = bus_off_ff;
      rsp_strobe_in = 1'b0;
      rsp_item_in   = '0;
      head_take     = 1'b0;
      meta_we       = 1'b0;
      meta_re       = 1'b0;
      word_we       = 1'b0;
      word_re       = 1'b0;
      word_waddr    = word_addr(write_slot_ff, push_beat_ff[BEAT_W-1:0]);
      word_raddr    = word_addr(read_slot_ff, '0);

      open_v  = open_ff;
      disc_v  = discarding_ff;
      pb_v    = push_beat_ff;
      drop_v  = drop_ff;
      kind_v  = KIND_STORED;
      sum_v   = {1'b0, len_rd_ff} + 8'd7;
      beats_v = (sum_v[6:3] == 4'd0) ? 4'd1 : sum_v[6:3];
      last_v  = (4'(beat_ff) + 4'd1 == beats_v);

      case (state_ff)
         S_IDLE: begin
            if (head_valid) begin
               head_take = 1'b1;
               case (head.op)
                  OP_PUSH: begin
                     // a first beat opens a frame, or a discard if the queue is full
                     if (head.first_beat) begin
                        open_v = 1'b1;
                        pb_v   = '0;
                        if (fill_ff >= FILL_W'(QUEUE_FRAMES)) begin
                           disc_v = 1'b1;
                           if (drop_ff != '1) begin
                              drop_v = drop_ff + 32'd1;
                           end
                        end else begin
                           disc_v  = 1'b0;
                           meta_we = 1'b1;
                        end
                     end
                     if (!open_v || disc_v) begin
                        kind_v = KIND_DROPPED;
                     end else begin
                        if (pb_v < PBEAT_W'(MAX_BEATS)) begin
                           word_we    = 1'b1;
                           word_waddr = word_addr(write_slot_ff, pb_v[BEAT_W-1:0]);
                           pb_v       = pb_v + 1'b1;
                        end
                        if (head.last_beat) begin
                           write_slot_in = next_slot(write_slot_ff);
                           fill_in       = fill_ff + 1'b1;
                        end
                     end
                     if (head.last_beat) begin
                        open_v = 1'b0;
                        disc_v = 1'b0;
                        pb_v   = '0;
                     end
                     open_in       = open_v;
                     discarding_in = disc_v;
                     push_beat_in  = pb_v;
                     drop_in       = drop_v;
                     rsp_strobe_in = 1'b1;
                     rsp_item_in.kind           = kind_v;
                     rsp_item_in.is_last        = 1'b1;
                     rsp_item_in.dropped_total  = drop_v;
                     rsp_item_in.bus_off_flag   = bus_off_ff;
                     rsp_item_in.frames_waiting = 4'(fill_in);
                  end
                  OP_POP: begin
                     if (fill_ff == '0) begin
                        rsp_strobe_in = 1'b1;
                        rsp_item_in.kind           = KIND_EMPTY;
                        rsp_item_in.is_last        = 1'b1;
                        rsp_item_in.dropped_total  = drop_ff;
                        rsp_item_in.bus_off_flag   = bus_off_ff;
                        rsp_item_in.frames_waiting = 4'(fill_ff);
                     end else begin
                        // fetch header and first word, beats follow from S_POP
                        meta_re      = 1'b1;
                        word_re      = 1'b1;
                        word_raddr   = word_addr(read_slot_ff, '0);
                        pop_slot_in  = read_slot_ff;
                        read_slot_in = next_slot(read_slot_ff);
                        fill_in      = fill_ff - 1'b1;
                        beat_in      = '0;
                        state_in     = S_POP;
                     end
                  end
                  default: begin
                     if (head.set_bus_off) begin
                        bus_off_in = 1'b1;
                     end
                     rsp_strobe_in = 1'b1;
                     rsp_item_in.kind           = KIND_STATUS;
                     rsp_item_in.is_last        = 1'b1;
                     rsp_item_in.dropped_total  = drop_ff;
                     rsp_item_in.bus_off_flag   = bus_off_in;
                     rsp_item_in.frames_waiting = 4'(fill_ff);
                  end
               endcase
            end
         end
         S_POP: begin
            rsp_strobe_in = 1'b1;
            rsp_item_in.kind           = KIND_BEAT;
            rsp_item_in.out_id         = id_rd_ff;
            rsp_item_in.out_length     = len_rd_ff;
            rsp_item_in.out_word       = word_rd_ff;
            rsp_item_in.beat_number    = 3'(beat_ff);
            rsp_item_in.is_last        = last_v;
            rsp_item_in.dropped_total  = drop_ff;
            rsp_item_in.bus_off_flag   = bus_off_ff;
            rsp_item_in.frames_waiting = 4'(fill_ff);
            if (last_v) begin
               state_in = S_IDLE;
            end else begin
               word_re    = 1'b1;
               word_raddr = word_addr(pop_slot_ff, beat_ff + BEAT_W'(1));
               beat_in    = beat_ff + BEAT_W'(1);
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (meta_we) begin
         id_mem_ff[write_slot_ff]  <= head.frame_id;
         len_mem_ff[write_slot_ff] <= head.length;
      end
      if (meta_re) begin
         id_rd_ff  <= id_mem_ff[read_slot_ff];
         len_rd_ff <= len_mem_ff[read_slot_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (word_we) begin
         word_mem_ff[word_waddr] <= head.data_word;
      end
      if (word_re) begin
         word_rd_ff <= word_mem_ff[word_raddr];
      end
   end

   always_ff @(posedge clock) begin
      rsp_item_ff <= rsp_item_in;
      pop_slot_ff <= pop_slot_in;
      beat_ff     <= beat_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         write_slot_ff <= '0;
         read_slot_ff  <= '0;
         fill_ff       <= '0;
         push_beat_ff  <= '0;
         open_ff       <= 1'b0;
         discarding_ff <= 1'b0;
         drop_ff       <= '0;
         bus_off_ff    <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         write_slot_ff <= write_slot_in;
         read_slot_ff  <= read_slot_in;
         fill_ff       <= fill_in;
         push_beat_ff  <= push_beat_in;
         open_ff       <= open_in;
         discarding_ff <= discarding_in;
         drop_ff       <= drop_in;
         bus_off_ff    <= bus_off_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

endmodule

// ----- hdl/crq_checker.sv -----
module crq_checker
   import crq_pkg::*;
(
   input logic         clock,
   input logic         reset,
   input logic         rsp_strobe,
   input out_item_type rsp_item
);

`include "can_rx_frame_queue_assert.svh"

   // a pop streams its beats without gaps
   `CRQ_ASSERT_NEXT(a_beats_contiguous, rsp_strobe && !rsp_item.is_last, rsp_strobe)

   // only frame beats can be non-final
   `CRQ_ASSERT_NOW(a_nonlast_is_beat, rsp_strobe && !rsp_item.is_last, rsp_item.kind == KIND_BEAT)

   // beat numbers advance by one inside a frame
   `CRQ_ASSERT_NEXT(a_beat_advance, rsp_strobe && !rsp_item.is_last, rsp_item.beat_number == 3'($past(rsp_item.beat_number) + 3'd1))

   // empty report only with nothing waiting
   `CRQ_ASSERT_NOW(a_empty_count, rsp_strobe && rsp_item.kind == KIND_EMPTY, rsp_item.frames_waiting == 4'd0)

endmodule

bind can_rx_frame_queue crq_checker u_checker (.*);

// ----- tb/sv/tb.sv -----
module tb;
   import crq_pkg::*;

   localparam int         WATCHDOG_LIMIT = 1000;
   localparam int         RANDOM_ITEMS   = 410;
   localparam int         DRAIN_CYCLES   = 24;
   localparam int         PRINT_LIMIT    = 100;
   localparam logic [1:0] CMD_SPARE      = 2'd3;  // unused code, answers with a status
   // Two copies of the queue state: one follows the plan while the stimulus is
   // built, the other follows the transactions that the block really accepts.
   localparam int         PLAN_COPY      = 0;
   localparam int         CHECK_COPY     = 1;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         start = 1'b0;
   logic         busy;
   in_item_type  req_item = '0;
   logic         rsp_strobe;
   out_item_type rsp_item;

   in_item_type  req_backlog [$];   // transactions still to be driven
   out_item_type rsp_owed [$];      // results the block still owes, oldest first
   int           error_count  = 0;
   int           sent_count   = 0;
   int           stall_cycles = 0;
   logic         req_taken    = 1'b0;

   logic [10:0]  id_mem          [2][QUEUE_FRAMES];
   logic [6:0]   len_mem         [2][QUEUE_FRAMES];
   logic [63:0]  word_mem        [2][WORDS];
   bit           word_seen       [2][WORDS];
   int           wr_slot         [2];
   int           rd_slot         [2];
   int           held            [2];
   int           beat_ptr        [2];
   bit           frame_open      [2];
   bit           discarding      [2];
   bit           bus_off_latched [2];
   logic [31:0]  drop_count      [2];

   can_rx_frame_queue DUT (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_item   (req_item),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item)
   );

   always #10 clock = ~clock;

   // ---------------------------------------------------------------------------
   // Queue predictor
   // ---------------------------------------------------------------------------

   // DLC to payload bytes, clipped to what one slot can hold.
   function automatic logic [6:0] stored_length(input logic [3:0] dlc);
      int bytes;
      if (dlc <= 4'd8) begin
         bytes = int'(dlc);
      end else if (dlc <= 4'd12) begin
         bytes = 8 + 4 * (dlc - 8);
      end else if (dlc == 4'd13) begin
         bytes = 32;
      end else if (dlc == 4'd14) begin
         bytes = 48;
      end else begin
         bytes = 64;
      end
      if (bytes > LEN_MAX) bytes = LEN_MAX;
      return bytes[6:0];
   endfunction

   // Beats a popped frame takes: ceil(len/8), at least one.
   function automatic int beats_for(input logic [6:0] len);
      int n;
      n = (len + 7) / 8;
      if (n == 0) n = 1;
      if (n > MAX_BEATS) n = MAX_BEATS;
      return n;
   endfunction

   task automatic reset_copy(input int c);
      wr_slot[c]         = 0;
      rd_slot[c]         = 0;
      held[c]            = 0;
      beat_ptr[c]        = 0;
      frame_open[c]      = 1'b0;
      discarding[c]      = 1'b0;
      bus_off_latched[c] = 1'b0;
      drop_count[c]      = '0;
      for (int w = 0; w < WORDS; w++) word_seen[c][w] = 1'b0;
   endtask

   // Queue one owed result; status fields reflect the state after the transaction.
   task automatic owe(input int c, input logic [2:0] kind, input logic [10:0] id,
                      input logic [6:0] len, input logic [63:0] word, input int beat,
                      input bit last);
      out_item_type r;
      r.kind           = kind;
      r.out_id         = id;
      r.out_length     = len;
      r.out_word       = word;
      r.beat_number    = beat[2:0];
      r.is_last        = last;
      r.dropped_total  = drop_count[c];
      r.bus_off_flag   = bus_off_latched[c];
      r.frames_waiting = held[c][3:0];
      if (c == CHECK_COPY) rsp_owed.push_back(r);
   endtask

   task automatic advance_rx_queue(input int c, input in_item_type it);
      int         slot;
      int         n;
      logic [2:0] kind;
      case (it.cmd)
         CMD_PUSH: begin
            if (it.first_beat) begin
               // a first beat abandons any open frame and decides keep or drop
               frame_open[c] = 1'b1;
               beat_ptr[c]   = 0;
               if (held[c] >= QUEUE_FRAMES) begin
                  discarding[c] = 1'b1;
                  if (drop_count[c] != '1) drop_count[c]++;
               end else begin
                  discarding[c]            = 1'b0;
                  id_mem[c][wr_slot[c]]    = it.frame_id;
                  len_mem[c][wr_slot[c]]   = stored_length(it.dlc_code);
               end
            end
            if (!frame_open[c] || discarding[c]) begin
               kind = KIND_DROPPED;
            end else begin
               kind = KIND_STORED;
               // beats past the slot's capacity are swallowed but still reported stored
               if (beat_ptr[c] < MAX_BEATS) begin
                  word_mem[c][wr_slot[c] * MAX_BEATS + beat_ptr[c]]  = it.data_word;
                  word_seen[c][wr_slot[c] * MAX_BEATS + beat_ptr[c]] = 1'b1;
                  beat_ptr[c]++;
               end
               if (it.last_beat) begin
                  wr_slot[c] = (wr_slot[c] + 1) % QUEUE_FRAMES;
                  held[c]++;
               end
            end
            if (it.last_beat) begin
               frame_open[c] = 1'b0;
               discarding[c] = 1'b0;
               beat_ptr[c]   = 0;
            end
            owe(c, kind, '0, '0, '0, 0, 1'b1);
         end
         CMD_POP: begin
            if (held[c] == 0) begin
               owe(c, KIND_EMPTY, '0, '0, '0, 0, 1'b1);
            end else begin
               slot       = rd_slot[c];
               n          = beats_for(len_mem[c][slot]);
               rd_slot[c] = (rd_slot[c] + 1) % QUEUE_FRAMES;
               held[c]--;
               for (int b = 0; b < n; b++)
                  owe(c, KIND_BEAT, id_mem[c][slot], len_mem[c][slot],
                      word_mem[c][slot * MAX_BEATS + b], b, b == n - 1);
            end
         end
         default: begin
            if (it.cmd == CMD_BUS_OFF) bus_off_latched[c] = 1'b1;
            owe(c, KIND_STATUS, '0, '0, '0, 0, 1'b1);
         end
      endcase
   endtask

   // ---------------------------------------------------------------------------
   // Stimulus construction
   // ---------------------------------------------------------------------------

   function automatic in_item_type random_item(input logic [1:0] cmd);
      in_item_type it;
      it.cmd        = cmd;
      it.frame_id   = 11'($urandom_range(2047));
      it.dlc_code   = 4'($urandom_range(15));
      it.data_word  = {$urandom, $urandom};
      it.first_beat = 1'($urandom_range(1));
      it.last_beat  = 1'($urandom_range(1));
      return it;
   endfunction

   // Tell whether closing the frame with the next push beat leaves every beat
   // that a later pop reads already written at least once. A slot word that was
   // never written must never be popped.
   function automatic bit close_ok(input bit first, input logic [3:0] dlc);
      int         slot;
      int         have;
      int         need;
      logic [6:0] len;
      slot = wr_slot[PLAN_COPY];
      if (first) begin
         if (held[PLAN_COPY] >= QUEUE_FRAMES) return 1'b1;
         len  = stored_length(dlc);
         have = 1;
      end else begin
         if (!frame_open[PLAN_COPY] || discarding[PLAN_COPY]) return 1'b1;
         len  = len_mem[PLAN_COPY][slot];
         have = (beat_ptr[PLAN_COPY] < MAX_BEATS) ? beat_ptr[PLAN_COPY] + 1 : MAX_BEATS;
      end
      need = beats_for(len);
      for (int b = have; b < need; b++)
         if (!word_seen[PLAN_COPY][slot * MAX_BEATS + b]) return 1'b0;
      return 1'b1;
   endfunction

   task automatic queue_item(input in_item_type it);
      req_backlog.push_back(it);
      advance_rx_queue(PLAN_COPY, it);
   endtask

   // Push a frame of nbeats beats; a closed frame gets its last beat marked, late
   // if stopping early would pop never-written words. Pops may slip in between.
   task automatic send_frame(input logic [10:0] id, input logic [3:0] dlc, input int nbeats,
                             input bit closed, input int pop_pct, input bit fixed,
                             input logic [63:0] pattern);
      in_item_type it;
      int          b;
      b = 0;
      forever begin
         it            = random_item(CMD_PUSH);
         it.first_beat = (b == 0);
         it.last_beat  = 1'b0;
         if (b == 0) begin
            it.frame_id = id;
            it.dlc_code = dlc;
         end
         if (fixed) it.data_word = pattern;
         if (closed && b + 1 >= nbeats && close_ok(b == 0, dlc)) it.last_beat = 1'b1;
         queue_item(it);
         b++;
         if (it.last_beat || (!closed && b >= nbeats)) break;
         if ($urandom_range(99) < pop_pct) queue_item(random_item(CMD_POP));
      end
   endtask

   initial begin : stimulus
      in_item_type it;
      logic [3:0]  dlc;
      int          r;
      int          nb;
      int          need;
      int          frame_pct;
      int          pop_pct;
      int          skipped;

      reset_copy(PLAN_COPY);
      reset_copy(CHECK_COPY);

      // Directed opening: empty pop, spare code, stray continuation beat, then
      // extreme frames (id/dlc/data all zero and all ones, beats past capacity),
      // an abandoned frame, pops through to empty again, and bus-off last so the
      // flag is seen low before it sticks.
      queue_item(random_item(CMD_POP));
      queue_item(random_item(CMD_SPARE));
      it            = random_item(CMD_PUSH);
      it.first_beat = 1'b0;
      it.last_beat  = 1'b1;
      queue_item(it);
      send_frame(11'd0, 4'd0, 1, 1'b1, 0, 1'b1, '0);
      send_frame(11'h7FF, 4'd15, MAX_BEATS + 1, 1'b1, 0, 1'b1, '1);
      send_frame(11'($urandom_range(2047)), 4'd8, 1, 1'b0, 0, 1'b0, '0);
      send_frame(11'($urandom_range(2047)), 4'd1, 1, 1'b1, 0, 1'b0, '0);
      repeat (4) queue_item(random_item(CMD_POP));
      queue_item(random_item(CMD_BUS_OFF));

      // Random part: alternate fill-heavy and drain-heavy phases so the queue
      // both overflows (drops) and runs dry (empty pops).
      skipped = 0;
      while (req_backlog.size() - skipped < 20 + RANDOM_ITEMS) begin
         if ((req_backlog.size() / 50) % 2 == 0) begin
            frame_pct = 80;
            pop_pct   = 10;
         end else begin
            frame_pct = 15;
            pop_pct   = 75;
         end
         r = $urandom_range(99);
         if (r < frame_pct) begin
            dlc  = 4'($urandom_range(15));
            need = beats_for(stored_length(dlc));
            r    = $urandom_range(99);
            if (r < 10) begin
               nb = $urandom_range(need, 1);           // short frame
            end else if (r < 20) begin
               nb = need + $urandom_range(2, 1);       // extra beats
            end else begin
               nb = need;
            end
            send_frame(11'($urandom_range(2047)), dlc, nb, $urandom_range(99) < 92, 8,
                       1'b0, '0);
         end else if (r < frame_pct + pop_pct) begin
            queue_item(random_item(CMD_POP));
         end else begin
            r = $urandom_range(2);
            if (r == 0) begin
               // continuation beat out of sequence; ignored unless a frame is open
               it            = random_item(CMD_PUSH);
               it.first_beat = 1'b0;
               if (!close_ok(1'b0, it.dlc_code)) it.last_beat = 1'b0;
               if (!frame_open[PLAN_COPY]) skipped++;
               queue_item(it);
            end else begin
               queue_item(random_item(r == 1 ? CMD_BUS_OFF : CMD_SPARE));
            end
         end
      end

      // Hold reset, then release it on a falling edge.
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Wait for the last transaction and every owed result, then let the pipe
      // drain to catch any stray result.
      while (req_backlog.size() != 0 || start || rsp_owed.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (error_count == 0) begin
         $display("[can_rx_frame_queue] OK");
      end else begin
         $display("[can_rx_frame_queue] ERROR");
      end
      $finish;
   end

   // ---------------------------------------------------------------------------
   // Driver: present the next transaction on the falling edge once the previous
   // one was taken; hold it while busy. Idle about 16% of the time, except for a
   // stretch of transactions driven back to back.
   // ---------------------------------------------------------------------------
   always @(negedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else if (!start || req_taken) begin
         if (req_backlog.size() != 0 &&
             ((sent_count >= 180 && sent_count < 300) || $urandom_range(99) >= 16)) begin
            req_item   <= req_backlog.pop_front();
            start      <= 1'b1;
            sent_count <= sent_count + 1;
         end else begin
            start <= 1'b0;
         end
      end
   end

   // ---------------------------------------------------------------------------
   // Monitor: on each rising edge advance the predictor for an accepted
   // transaction and compare a strobed result with the oldest owed one.
   // ---------------------------------------------------------------------------
   task automatic report_mismatch(input string msg);
      error_count++;
      if (error_count <= PRINT_LIMIT) $display("mismatch at %0t: %s", $time, msg);
   endtask

   task automatic check_field(input string name, input logic [63:0] got,
                              input logic [63:0] want);
      if (got !== want) report_mismatch($sformatf("%s got %0h, want %0h", name, got, want));
   endtask

   always @(posedge clock) begin : monitor
      out_item_type want;
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         req_taken <= start && busy === 1'b0;
         if (start && busy === 1'b0) advance_rx_queue(CHECK_COPY, req_item);
         if (rsp_strobe === 1'b1) begin
            if (rsp_owed.size() == 0) begin
               report_mismatch($sformatf("result of kind %0d with none owed", rsp_item.kind));
            end else begin
               want = rsp_owed.pop_front();
               check_field("kind", 64'(rsp_item.kind), 64'(want.kind));
               check_field("out_id", 64'(rsp_item.out_id), 64'(want.out_id));
               check_field("out_length", 64'(rsp_item.out_length), 64'(want.out_length));
               check_field("out_word", rsp_item.out_word, want.out_word);
               check_field("beat_number", 64'(rsp_item.beat_number),
                           64'(want.beat_number));
               check_field("is_last", 64'(rsp_item.is_last), 64'(want.is_last));
               check_field("dropped_total", 64'(rsp_item.dropped_total),
                           64'(want.dropped_total));
               check_field("bus_off_flag", 64'(rsp_item.bus_off_flag),
                           64'(want.bus_off_flag));
               check_field("frames_waiting", 64'(rsp_item.frames_waiting),
                           64'(want.frames_waiting));
            end
         end
      end
   end

   // Watchdog: end the run when nothing moves for too long.
   always @(posedge clock) begin
      if (reset || (start && busy === 1'b0) || rsp_strobe === 1'b1) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= WATCHDOG_LIMIT) begin
         $display("[can_rx_frame_queue] ERROR");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

endmodule
